[sv/uvs_pkg.sv]
// shared types, constants and helpers for the uv sphere vertex generator
// no dependencies
package uvs_pkg;

  localparam int DefRings = 48;
  localparam int DefSegs  = 96;
  localparam int CordicIters = 16;
  localparam int Gain = 636751;

  localparam logic [2:0] REG_YAW_START = 3'd0;
  localparam logic [2:0] REG_YAW_SPAN  = 3'd1;
  localparam logic [2:0] REG_U_MIN     = 3'd2;
  localparam logic [2:0] REG_U_MAX     = 3'd3;
  localparam logic [2:0] REG_RADIUS    = 3'd4;

  function automatic logic signed [24:0] atan_of(input int i);
    unique case (i)
      0: atan_of = 25'sd2097152;
      1: atan_of = 25'sd1238021;
      2: atan_of = 25'sd654136;
      3: atan_of = 25'sd332050;
      4: atan_of = 25'sd166669;
      5: atan_of = 25'sd83416;
      6: atan_of = 25'sd41718;
      7: atan_of = 25'sd20860;
      8: atan_of = 25'sd10430;
      9: atan_of = 25'sd5215;
      10: atan_of = 25'sd2608;
      11: atan_of = 25'sd1304;
      12: atan_of = 25'sd652;
      13: atan_of = 25'sd326;
      14: atan_of = 25'sd163;
      default: atan_of = 25'sd81;
    endcase
  endfunction

  // cordic vector for both angles, plus the side data that rides along
  typedef struct packed {
    logic signed [22:0] px;
    logic signed [22:0] py;
    logic signed [24:0] pz;
    logic               pflip;
    logic signed [22:0] yx;
    logic signed [22:0] yy;
    logic signed [24:0] yz;
    logic               yflip;
    logic [15:0]        radius;
    logic [15:0]        tu;
    logic [15:0]        tv;
  } cell_t;

endpackage

[sv/uvs_cell.sv]
// one cordic iteration for the pitch and yaw rotations, registered
// depends on uvs_pkg
module uvs_cell #(
  parameter int Stage = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          stall,
  input  logic          in_valid,
  input  uvs_pkg::cell_t in_data,
  output logic          out_valid,
  output uvs_pkg::cell_t out_data
);
  import uvs_pkg::*;

  cell_t nxt;

  always_comb begin
    nxt = in_data;
    if (in_data.pz >= 0) begin
      nxt.px = in_data.px - (in_data.py >>> Stage);
      nxt.py = in_data.py + (in_data.px >>> Stage);
      nxt.pz = in_data.pz - atan_of(Stage);
    end else begin
      nxt.px = in_data.px + (in_data.py >>> Stage);
      nxt.py = in_data.py - (in_data.px >>> Stage);
      nxt.pz = in_data.pz + atan_of(Stage);
    end
    if (in_data.yz >= 0) begin
      nxt.yx = in_data.yx - (in_data.yy >>> Stage);
      nxt.yy = in_data.yy + (in_data.yx >>> Stage);
      nxt.yz = in_data.yz - atan_of(Stage);
    end else begin
      nxt.yx = in_data.yx + (in_data.yy >>> Stage);
      nxt.yy = in_data.yy - (in_data.yx >>> Stage);
      nxt.yz = in_data.yz + atan_of(Stage);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!stall) begin
      out_valid <= in_valid;
    end
    if (!stall) begin
      out_data <= nxt;
    end
  end
endmodule

[sv/uvs_front.sv]
// front end: grid point to angles, texture coordinates and cordic start vectors
// depends on uvs_pkg
module uvs_front #(
  parameter int Rings = uvs_pkg::DefRings,
  parameter int Segs  = uvs_pkg::DefSegs
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          stall,
  input  logic          in_valid,
  input  logic [5:0]    ring_index,
  input  logic [6:0]    seg_index,
  input  logic [15:0]   yaw_start,
  input  logic [16:0]   yaw_span,
  input  logic [15:0]   u_min,
  input  logic [15:0]   u_max,
  input  logic [15:0]   sphere_radius,
  output logic          out_valid,
  output uvs_pkg::cell_t out_data
);
  import uvs_pkg::*;

  // division by constants via reciprocal multiply: 2^32/(2*N), or 2^32/N for u, rounded up
  localparam longint RecR = ((64'd1 << 32) + 2 * Rings - 1) / (2 * Rings);
  localparam longint RecS = ((64'd1 << 32) + 2 * Segs - 1) / (2 * Segs);
  localparam longint RecU = ((64'd1 << 32) + Segs - 1) / Segs;

  // stage a registers
  logic        a_valid;
  logic [21:0] a_q;
  logic [24:0] a_ynum;
  logic [23:0] a_unum;
  logic [15:0] a_ys, a_radius;

  logic [24:0] ynum;
  logic signed [25:0] un_s;
  logic [23:0] un_c;
  logic [47:0] qprod, yprod, uprod;
  logic [16:0] q;
  logic [15:0] yoff, tu, pitch, yaw;

  always_comb begin
    un_s = $signed({10'd0, u_min}) * $signed(26'(Segs))
         + ($signed({10'd0, u_max}) - $signed({10'd0, u_min})) * $signed({19'd0, seg_index});
    if (un_s < 0) un_c = '0;
    else if (un_s > 26'(32768 * Segs)) un_c = 24'(32768 * Segs);
    else un_c = un_s[23:0];
    ynum = 25'(yaw_span * seg_index * 2 + Segs);
  end

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (!stall) a_valid <= in_valid;
    if (!stall) begin
      a_q      <= 22'({ring_index, 16'd0} + Rings);
      a_ynum   <= ynum;
      a_unum   <= 24'(un_c + Segs / 2);
      a_ys     <= yaw_start;
      a_radius <= sphere_radius;
    end
  end

  // exact for these numerator ranges with a ceiling reciprocal and 32 bit shift
  // only the low 16 bits of the yaw quotient matter, so its product may wrap
  assign qprod = 48'(a_q) * 48'(RecR);
  assign yprod = 48'(a_ynum) * 48'(RecS);
  assign uprod = 48'(a_unum) * 48'(RecU);
  assign q     = {1'b0, qprod[47:32]};
  assign yoff  = yprod[47:32];
  assign tu    = (uprod[47:32] > 16'd32768) ? 16'd32768 : uprod[47:32];
  assign pitch = q[15:0] + 16'd49152;
  assign yaw   = a_ys + yoff;

  function automatic void fold(input logic [15:0] ang, output logic signed [24:0] z,
                               output logic flip);
    logic signed [24:0] w;
    w = $signed({1'b0, ang, 8'd0});
    flip = 1'b0;
    z = w;
    if (w >= 25'sd4194304 && w < 25'sd12582912) begin
      z = w - 25'sd8388608;
      flip = 1'b1;
    end else if (w >= 25'sd12582912) begin
      // one full turn below the widened angle
      z = $signed({1'b1, ang, 8'd0});
    end
  endfunction

  cell_t nd;
  always_comb begin
    nd = '0;
    fold(pitch, nd.pz, nd.pflip);
    fold(yaw, nd.yz, nd.yflip);
    nd.px = 23'(Gain);
    nd.yx = 23'(Gain);
    nd.py = '0;
    nd.yy = '0;
    nd.radius = a_radius;
    nd.tu = tu;
    nd.tv = (q > 17'd32768) ? 16'd32768 : q[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (!stall) out_valid <= a_valid;
    if (!stall) out_data <= nd;
  end
endmodule

[sv/uvs_back.sv]
// back end: radius scaling, rounding and saturation of the positions
// depends on uvs_pkg
module uvs_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          stall,
  input  logic          in_valid,
  input  uvs_pkg::cell_t in_data,
  output logic          out_valid,
  output logic signed [16:0] pos_x,
  output logic signed [16:0] pos_y,
  output logic signed [16:0] pos_z,
  output logic [15:0]   tex_u,
  output logic [15:0]   tex_v
);
  import uvs_pkg::*;

  logic signed [22:0] cpf, spf, cyf, syf;
  logic               b_valid, c_valid;
  logic signed [38:0] b_rcp, b_rsp;
  logic signed [21:0] b_cy, b_sy;
  logic [15:0]        b_tu, b_tv, c_tu, c_tv;
  logic signed [16:0] c_py;
  logic signed [38:0] c_rcp_hi;
  logic signed [21:0] c_cy, c_sy;
  logic [19:0]        c_rcp_lo;
  logic signed [60:0] hx, hz;
  logic signed [42:0] lx, lz;

  always_comb begin
    cpf = in_data.pflip ? -in_data.px : in_data.px;
    spf = in_data.pflip ? -in_data.py : in_data.py;
    cyf = in_data.yflip ? -in_data.yx : in_data.yx;
    syf = in_data.yflip ? -in_data.yy : in_data.yy;
  end

  function automatic logic signed [16:0] sat(input logic signed [63:0] v);
    if (v > 64'sd65535) sat = 17'sd65535;
    else if (v < -64'sd65535) sat = -17'sd65535;
    else sat = v[16:0];
  endfunction

  // stage b: radius times pitch terms
  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (!stall) b_valid <= in_valid;
    if (!stall) begin
      b_rcp <= 39'($signed({1'b0, in_data.radius}) * cpf);
      b_rsp <= 39'($signed({1'b0, in_data.radius}) * spf);
      b_cy  <= 22'(cyf);
      b_sy  <= 22'(syf);
      b_tu  <= in_data.tu;
      b_tv  <= in_data.tv;
    end
  end

  // stage c: sin pitch done; split rcp into high and low parts for the yaw products
  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (!stall) c_valid <= b_valid;
    if (!stall) begin
      c_py     <= sat(64'((64'(b_rsp) + 64'sd524288) >>> 20));
      c_rcp_hi <= b_rcp >>> 20;
      c_rcp_lo <= b_rcp[19:0];
      c_cy     <= b_cy;
      c_sy     <= b_sy;
      c_tu     <= b_tu;
      c_tv     <= b_tv;
    end
  end

  always_comb begin
    hx = 61'(c_rcp_hi * c_cy);
    hz = 61'(c_rcp_hi * c_sy);
    lx = 43'($signed({1'b0, c_rcp_lo}) * c_cy);
    lz = 43'($signed({1'b0, c_rcp_lo}) * c_sy);
  end

  logic signed [63:0] sx, sz;
  assign sx = (64'(hx) <<< 20) + 64'(lx) + 64'sd549755813888;
  assign sz = (64'(hz) <<< 20) + 64'(lz) + 64'sd549755813888;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (!stall) out_valid <= c_valid;
    if (!stall) begin
      pos_x <= sat(sx >>> 40);
      pos_z <= sat(sz >>> 40);
      pos_y <= c_py;
      tex_u <= c_tu;
      tex_v <= c_tv;
    end
  end
endmodule

[sv/uv_sphere_vertex_generator.sv]
// Accepts one grid point per cycle and returns its vertex after two
// front stages (reciprocal divides, angle fold), a chain of 16 CORDIC cells, and
// three back stages for the radius products. Throughput is one vertex per cycle;
// a stall on the output freezes the whole pipeline, and in_stall is high exactly
// when a finished vertex is held by out_stall.
module uv_sphere_vertex_generator #(
  parameter int Rings = uvs_pkg::DefRings,
  parameter int Segs  = uvs_pkg::DefSegs
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [5:0] ring_index,
  input  logic [6:0] seg_index,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [16:0] pos_x,
  output logic signed [16:0] pos_y,
  output logic signed [16:0] pos_z,
  output logic [15:0] tex_u,
  output logic [15:0] tex_v,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [16:0] cfg_data
);
  import uvs_pkg::*;

  logic [15:0] yaw_start, u_min, u_max, sphere_radius;
  logic [16:0] yaw_span;
  logic stall;

  // pipeline only halts when a finished vertex is held and not taken
  assign stall = out_valid & out_stall;
  assign in_stall = stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_start     <= 16'd16384;
      yaw_span      <= 17'd65536;
      u_min         <= 16'd0;
      u_max         <= 16'd32768;
      sphere_radius <= 16'd12800;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_YAW_START: yaw_start     <= cfg_data[15:0];
        REG_YAW_SPAN:  yaw_span      <= cfg_data;
        REG_U_MIN:     u_min         <= cfg_data[15:0];
        REG_U_MAX:     u_max         <= cfg_data[15:0];
        REG_RADIUS:    sphere_radius <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic  v [CordicIters+1];
  cell_t d [CordicIters+1];

  uvs_front #(.Rings(Rings), .Segs(Segs)) u_front (
    .clk, .rst, .stall, .in_valid, .ring_index, .seg_index,
    .yaw_start, .yaw_span, .u_min, .u_max, .sphere_radius,
    .out_valid(v[0]), .out_data(d[0])
  );

  for (genvar i = 0; i < CordicIters; i++) begin : g_cell
    uvs_cell #(.Stage(i)) u_cell (
      .clk, .rst, .stall,
      .in_valid(v[i]), .in_data(d[i]),
      .out_valid(v[i+1]), .out_data(d[i+1])
    );
  end

  uvs_back u_back (
    .clk, .rst, .stall,
    .in_valid(v[CordicIters]), .in_data(d[CordicIters]),
    .out_valid, .pos_x, .pos_y, .pos_z, .tex_u, .tex_v
  );
endmodule

[test/tb.sv]
// testbench for uv_sphere_vertex_generator: drives grid points, predicts each vertex
// with its own cordic model and compares every output field in order
// depends on uvs_pkg and the generator rtl
`timescale 1ns / 1ps

typedef struct packed {
  logic signed [16:0] x;
  logic signed [16:0] y;
  logic signed [16:0] z;
  logic [15:0]        u;
  logic [15:0]        v;
} vertex_t;

class vertex_scoreboard;
  localparam longint Rings = 48;
  localparam longint Segs  = 96;
  int unsigned yaw_start, yaw_span, u_min, u_max, radius;
  vertex_t want_q[$];
  int errors;

  function new();
    yaw_start = 16384;
    yaw_span  = 65536;
    u_min     = 0;
    u_max     = 32768;
    radius    = 12800;
    errors    = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [16:0] d);
    case (idx)
      uvs_pkg::REG_YAW_START: yaw_start = d[15:0];
      uvs_pkg::REG_YAW_SPAN:  yaw_span  = d;
      uvs_pkg::REG_U_MIN:     u_min     = d[15:0];
      uvs_pkg::REG_U_MAX:     u_max     = d[15:0];
      uvs_pkg::REG_RADIUS:    radius    = d[15:0];
      default: ;
    endcase
  endfunction

  static function longint sat17(longint v);
    if (v > 65535) return 65535;
    if (v < -65535) return -65535;
    return v;
  endfunction

  static function longint rnd_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  // rotation-mode cordic on a 16-bit binary angle, 20 fraction bits out
  static function void sin_cos(logic [15:0] ang, output longint c, output longint s);
    longint atan_tbl[16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                             20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) << 8;
    x = 636751;
    y = 0;
    flip = 0;
    if (z >= (1 << 22) && z < 3 * (1 << 22)) begin
      z -= 1 << 23;
      flip = 1;
    end else if (z >= 3 * (1 << 22)) begin
      z -= 1 << 24;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tbl[i];
      end else begin
        x += dx; y -= dy; z += atan_tbl[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function void note_point(logic [5:0] ring, logic [6:0] seg);
    longint q, yoff, cp, sp, cy, sy, rcp, num, tu;
    logic [15:0] pitch, yaw;
    vertex_t w;
    q = (longint'(ring) * 65536 + Rings) / (2 * Rings);
    pitch = 16'(q + 49152);
    yoff = (longint'(yaw_span) * seg * 2 + Segs) / (2 * Segs);
    yaw = 16'(yaw_start + yoff);
    sin_cos(pitch, cp, sp);
    sin_cos(yaw, cy, sy);
    rcp = longint'(radius) * cp;
    w.y = 17'(sat17(rnd_shift(longint'(radius) * sp, 20)));
    w.x = 17'(sat17(rnd_shift(rcp * cy, 40)));
    w.z = 17'(sat17(rnd_shift(rcp * sy, 40)));
    num = longint'(u_min) * Segs + (longint'(u_max) - longint'(u_min)) * seg;
    if (num < 0) num = 0;
    if (num > 32768 * Segs) num = 32768 * Segs;
    tu = (num + Segs / 2) / Segs;
    if (tu > 32768) tu = 32768;
    w.u = 16'(tu);
    w.v = q > 32768 ? 16'd32768 : 16'(q);
    want_q = {want_q, w};
  endfunction

  function void check_vertex(vertex_t got);
    vertex_t w;
    if (want_q.size() == 0) begin
      $error("vertex out with none expected");
      errors++;
      return;
    end
    w = want_q.pop_front();
    if (got.x !== w.x) begin
      $error("pos_x expected %0d actual %0d", w.x, got.x); errors++;
    end
    if (got.y !== w.y) begin
      $error("pos_y expected %0d actual %0d", w.y, got.y); errors++;
    end
    if (got.z !== w.z) begin
      $error("pos_z expected %0d actual %0d", w.z, got.z); errors++;
    end
    if (got.u !== w.u) begin
      $error("tex_u expected %0d actual %0d", w.u, got.u); errors++;
    end
    if (got.v !== w.v) begin
      $error("tex_v expected %0d actual %0d", w.v, got.v); errors++;
    end
  endfunction
endclass

module tb;
  import uvs_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [5:0] ring_index = 0;
  logic [6:0] seg_index = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [16:0] pos_x, pos_y, pos_z;
  logic [15:0] tex_u, tex_v;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [16:0] cfg_data = 0;

  vertex_scoreboard sb = new();
  bit gaps_on = 1;
  int hold_cycles = 0;
  int stall_left = 0;
  longint cycles = 0;

  uv_sphere_vertex_generator u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_point(ring_index, seg_index);
    if (!rst && out_valid && !out_stall) sb.check_vertex({pos_x, pos_y, pos_z, tex_u, tex_v});
  end

  // receiver: long hold-off when asked, else random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall <= 1;
        stall_left--;
      end else begin
        out_stall <= 0;
        if (gaps_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 12);
      end
    end
  end

  task automatic send_point(logic [5:0] r, logic [6:0] s);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1;
    ring_index <= r;
    seg_index <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] d);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  // leaves the write enable high; the caller drops it after its last write
  task automatic write_all(int unsigned ys, int unsigned sp, int unsigned umn,
                           int unsigned umx, int unsigned rad);
    write_reg(REG_YAW_START, 17'(ys));
    write_reg(REG_YAW_SPAN, 17'(sp));
    write_reg(REG_U_MIN, 17'(umn));
    write_reg(REG_U_MAX, 17'(umx));
    write_reg(REG_RADIUS, 17'(rad));
  endtask

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8)
        send_point(6'($urandom_range(0, 48)), 7'($urandom_range(0, 96)));
      else
        send_point(6'($urandom), 7'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // poles, equator, seam and out-of-range indexes at reset values
    send_point(0, 0);
    send_point(48, 96);
    send_point(24, 48);
    send_point(12, 24);
    send_point(36, 72);
    send_point(63, 127);
    send_point(49, 97);
    send_point(0, 127);
    send_point(63, 0);
    send_point(1, 1);
    drain();

    // extremes: zero span, max radius, reversed texture range
    write_all(0, 0, 32768, 0, 65535);
    cfg_we <= 0;
    send_point(0, 0);
    send_point(24, 96);
    send_point(48, 127);
    send_point(36, 5);
    send_point(24, 0);
    drain();
    // span beyond one turn, top yaw start, equal u limits, zero radius
    write_all(65535, 131071, 20000, 20000, 0);
    write_reg(3'd5, 17'h1ffff);
    write_reg(3'd7, 17'h0);
    cfg_we <= 0;
    send_point(24, 96);
    send_point(10, 127);
    send_point(63, 50);
    send_point(48, 0);
    drain();
    write_all(0, 65536, 65535, 65535, 65535);
    cfg_we <= 0;
    send_point(24, 96);
    send_point(24, 127);
    send_point(0, 50);
    drain();

    // fill the pipeline against a long output hold
    gaps_on = 0;
    hold_cycles = 300;
    random_points(80);
    drain();
    gaps_on = 1;

    for (int ph = 0; ph < 8; ph++) begin
      write_all($urandom_range(0, 65535), $urandom_range(0, 131071),
                $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535));
      cfg_we <= 0;
      if (ph == 7) gaps_on = 0;
      random_points(150);
      drain();
    end

    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

[sim.f]
sv/uvs_pkg.sv
sv/uvs_cell.sv
sv/uvs_front.sv
sv/uvs_back.sv
sv/uv_sphere_vertex_generator.sv
test/tb.sv
